### sv/lsf_pkg.sv
// Shared definitions for the learning switch forwarder.
// Request codes, fixed field widths, parameter defaults and the control and
// status structs between the top level and the address table. No dependencies.
package lsf_pkg;

   // fixed field widths
   localparam int TYPE_W     = 2;
   localparam int PSEL_W     = 4;
   localparam int SID_W      = 16;
   localparam int MASK_W     = 16;
   localparam int CSR_W      = 5;

   // parameter defaults
   localparam int MAX_PORTS_DEF     = 16;
   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int ID_BITS_DEF       = 16;

   // port limit after reset
   localparam int PORT_COUNT_RESET = 16;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_CONNECT    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FRAME      = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_DISCONNECT = 2'd2;

   // commands into the address table, valid for the cycle the stage advances
   typedef struct packed {
      logic frame;        // accepted frame: learn source if new
      logic disconnect;   // drop every entry bound to the port
   } tbl_cmd_type;

   // lookup results out of the address table
   typedef struct packed {
      logic              src_hit;
      logic [PSEL_W-1:0] src_port;
      logic              dst_hit;
      logic [PSEL_W-1:0] dst_port;
   } tbl_stat_type;

endpackage

### sv/lsf_addr_table.sv
// Station address table of the learning switch forwarder: flip-flop CAM with
// parallel source and destination compare, learning and per-port flush.
// Depends on lsf_pkg.
module lsf_addr_table #(
   parameter int TABLE_ENTRIES = lsf_pkg::TABLE_ENTRIES_DEF,
   parameter int ID_BITS       = lsf_pkg::ID_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lsf_pkg::tbl_cmd_type      cmd,
   input  logic [lsf_pkg::PSEL_W-1:0] port,
   input  logic [ID_BITS-1:0]        src_key,
   input  logic [ID_BITS-1:0]        dst_key,
   output lsf_pkg::tbl_stat_type     stat
);

   localparam int EIDX_W = $clog2(TABLE_ENTRIES);

   logic [TABLE_ENTRIES-1:0]   valid_ff, valid_in;
   logic [ID_BITS-1:0]         station_ff [TABLE_ENTRIES];
   logic [lsf_pkg::PSEL_W-1:0] port_ff    [TABLE_ENTRIES];

   logic [TABLE_ENTRIES-1:0]   src_match, dst_match;
   logic [lsf_pkg::PSEL_W-1:0] src_port, dst_old_port;
   logic                       src_hit, dst_old_hit;
   logic [EIDX_W-1:0]          free_idx;
   logic                       free_found, learn;

   // parallel compare; stations are unique so matches are one-hot
   always_comb begin
      src_port     = '0;
      dst_old_port = '0;
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
         src_match[e] = valid_ff[e] && (station_ff[e] == src_key);
         dst_match[e] = valid_ff[e] && (station_ff[e] == dst_key);
         if (src_match[e]) src_port = src_port | port_ff[e];
         if (dst_match[e]) dst_old_port = dst_old_port | port_ff[e];
      end
      src_hit     = |src_match;
      dst_old_hit = |dst_match;
   end

   // lowest empty entry
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
         if (!valid_ff[e]) begin
            free_idx   = EIDX_W'(e);
            free_found = 1'b1;
         end
      end
   end

   assign learn = cmd.frame && !src_hit && free_found;

   // destination lookup sees the entry learned by this same frame
   always_comb begin
      stat.src_hit  = src_hit;
      stat.src_port = src_port;
      if (dst_old_hit) begin
         stat.dst_hit  = 1'b1;
         stat.dst_port = dst_old_port;
      end else if (learn && (dst_key == src_key)) begin
         stat.dst_hit  = 1'b1;
         stat.dst_port = port;
      end else begin
         stat.dst_hit  = 1'b0;
         stat.dst_port = '0;
      end
   end

   // valid bits: set on learn, flush entries of a disconnected port
   always_comb begin
      valid_in = valid_ff;
      if (learn) valid_in[free_idx] = 1'b1;
      if (cmd.disconnect) begin
         for (int e = 0; e < TABLE_ENTRIES; e++) begin
            if (port_ff[e] == port) valid_in[e] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry payload, written only on learn
   always_ff @(posedge clock) begin
      if (learn) begin
         station_ff[free_idx] <= src_key;
         port_ff[free_idx]    <= port;
      end
   end

endmodule

### sv/learning_switch_forwarder.sv
// Learning switch forwarder, top level: request stage, port bookkeeping,
// result register. Depends on lsf_pkg and lsf_addr_table.
//
// Usage:
//   Requests (connect, frame, disconnect) enter on req_* with valid/stall; a
//   request transfers on a clock edge with req_valid high and req_stall low.
//   Each request yields exactly one result on rsp_* with the same handshake.
//   rsp_valid rises when the request leaves the request register and the
//   result register loads. One request is taken every cycle unless req_stall is high:
//   it waits in the request register, where the address table CAM,
//   the free port search and the flood mask are evaluated against the
//   current state, and the state update and result register load happen at
//   the same edge, so the next request sees the updated table.
//   When rsp_stall holds a result, the request register keeps its item and
//   req_stall is high only while both registers are full and rsp_stall is high.
//   csr_wr_en writes the port limit (take effect at once on the free port
//   count); write it only while no request is in flight.
//   Synchronous reset empties the table and both registers, disconnects all
//   ports and loads the limit of 16 ports, capped at MAX_PORTS. No clearing pass is needed.
module learning_switch_forwarder #(
   parameter int MAX_PORTS     = lsf_pkg::MAX_PORTS_DEF,
   parameter int TABLE_ENTRIES = lsf_pkg::TABLE_ENTRIES_DEF,
   parameter int ID_BITS       = lsf_pkg::ID_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lsf_pkg::TYPE_W-1:0]  req_type,
   input  logic [lsf_pkg::PSEL_W-1:0]  req_port_sel,
   input  logic [lsf_pkg::SID_W-1:0]   req_src_id,
   input  logic [lsf_pkg::SID_W-1:0]   req_dst_id,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_ok,
   output logic [lsf_pkg::PSEL_W-1:0]  rsp_assigned_port,
   output logic [lsf_pkg::MASK_W-1:0]  rsp_forward_mask,
   output logic                        rsp_dest_hit,
   // configuration
   input  logic                        csr_wr_en,
   input  logic [lsf_pkg::CSR_W-1:0]   csr_wr_data
);

   localparam int PIDX_W     = $clog2(MAX_PORTS);
   localparam int CNT_W      = $clog2(MAX_PORTS + 1);
   localparam int LIM_W      = (CNT_W > lsf_pkg::CSR_W) ? CNT_W : lsf_pkg::CSR_W;
   localparam int PSEL_SPAN  = 1 << lsf_pkg::PSEL_W;
   localparam int FREE_RESET = (lsf_pkg::PORT_COUNT_RESET < MAX_PORTS) ?
                               lsf_pkg::PORT_COUNT_RESET : MAX_PORTS;

   // request register
   logic                       stg_valid_ff, stg_valid_in;
   logic [lsf_pkg::TYPE_W-1:0] stg_type_ff;
   logic [lsf_pkg::PSEL_W-1:0] stg_port_ff;
   logic [ID_BITS-1:0]         stg_src_ff, stg_dst_ff;

   // port state
   logic [MAX_PORTS-1:0]       port_active_ff, port_active_in;
   logic [CNT_W-1:0]           active_cnt_ff, active_cnt_in;
   logic [CNT_W-1:0]           free_ports_ff, free_ports_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic [lsf_pkg::PSEL_W-1:0] rsp_port_ff, rsp_port_in;
   logic [lsf_pkg::MASK_W-1:0] rsp_mask_ff, rsp_mask_in;
   logic                       rsp_hit_ff, rsp_hit_in;

   logic                       out_free, stage_go, req_xfer;
   logic [PSEL_SPAN-1:0]       active_ext;
   logic                       port_ok;
   logic [PIDX_W-1:0]          free_idx;
   logic                       free_found, connect_ok;
   logic [lsf_pkg::PSEL_W-1:0] excl_port;
   logic [lsf_pkg::MASK_W-1:0] flood_mask;
   logic [LIM_W-1:0]           lim_wide;
   logic [CNT_W-1:0]           lim_new, free_cfg;
   lsf_pkg::tbl_cmd_type       tbl_cmd;
   lsf_pkg::tbl_stat_type      tbl_stat;

   // handshake: stage advances when the result register is empty or draining
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign stage_go  = stg_valid_ff && out_free;
   assign req_stall = stg_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   // active bits over the whole port_sel range, zero beyond MAX_PORTS
   always_comb begin
      for (int i = 0; i < PSEL_SPAN; i++) begin
         active_ext[i] = (i < MAX_PORTS) ? port_active_ff[i] : 1'b0;
      end
   end
   assign port_ok = active_ext[stg_port_ff];

   // lowest inactive port for a connect
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = MAX_PORTS - 1; i >= 0; i--) begin
         if (!port_active_ff[i]) begin
            free_idx   = PIDX_W'(i);
            free_found = 1'b1;
         end
      end
   end
   assign connect_ok = (free_ports_ff != '0) && free_found;

   // flood to active ports except the source's learned port, or the request port if the source is unknown
   assign excl_port = tbl_stat.src_hit ? tbl_stat.src_port : stg_port_ff;
   always_comb begin
      for (int i = 0; i < lsf_pkg::MASK_W; i++) begin
         flood_mask[i] = active_ext[i] && (i != int'(excl_port));
      end
   end

   // table commands
   assign tbl_cmd.frame      = stage_go && (stg_type_ff == lsf_pkg::REQ_FRAME) && port_ok;
   assign tbl_cmd.disconnect = stage_go && (stg_type_ff == lsf_pkg::REQ_DISCONNECT) &&
                               port_ok;

   lsf_addr_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ID_BITS       (ID_BITS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tbl_cmd),
      .port    (stg_port_ff),
      .src_key (stg_src_ff),
      .dst_key (stg_dst_ff),
      .stat    (tbl_stat)
   );

   // result fields
   always_comb begin
      rsp_ok_in   = 1'b0;
      rsp_port_in = '0;
      rsp_mask_in = '0;
      rsp_hit_in  = 1'b0;
      case (stg_type_ff)
         lsf_pkg::REQ_CONNECT: begin
            rsp_ok_in = connect_ok;
            if (connect_ok) rsp_port_in = lsf_pkg::PSEL_W'(free_idx);
         end
         lsf_pkg::REQ_FRAME: begin
            rsp_ok_in = port_ok;
            if (port_ok) begin
               rsp_hit_in  = tbl_stat.dst_hit;
               rsp_mask_in = tbl_stat.dst_hit ?
                             (lsf_pkg::MASK_W'(1) << tbl_stat.dst_port) : flood_mask;
            end
         end
         lsf_pkg::REQ_DISCONNECT: begin
            rsp_ok_in = port_ok;
         end
         default: begin
            rsp_ok_in = 1'b0;
         end
      endcase
   end

   // free port count reloaded by a limit write
   always_comb begin
      lim_wide = (LIM_W'(csr_wr_data) > LIM_W'(MAX_PORTS)) ?
                 LIM_W'(MAX_PORTS) : LIM_W'(csr_wr_data);
      lim_new  = CNT_W'(lim_wide);
      free_cfg = (lim_new > active_cnt_ff) ? (lim_new - active_cnt_ff) : '0;
   end

   // port state update
   always_comb begin
      port_active_in = port_active_ff;
      active_cnt_in  = active_cnt_ff;
      free_ports_in  = free_ports_ff;
      if (csr_wr_en) begin
         free_ports_in = free_cfg;
      end else if (stage_go) begin
         if ((stg_type_ff == lsf_pkg::REQ_CONNECT) && connect_ok) begin
            port_active_in[free_idx] = 1'b1;
            active_cnt_in = active_cnt_ff + CNT_W'(1);
            free_ports_in = free_ports_ff - CNT_W'(1);
         end else if ((stg_type_ff == lsf_pkg::REQ_DISCONNECT) && port_ok) begin
            for (int i = 0; i < MAX_PORTS; i++) begin
               if (int'(stg_port_ff) == i) port_active_in[i] = 1'b0;
            end
            active_cnt_in = active_cnt_ff - CNT_W'(1);
            free_ports_in = free_ports_ff + CNT_W'(1);
         end
      end
   end

   // register valid flags
   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (req_xfer) stg_valid_in = 1'b1;
      else if (stage_go) stg_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (stage_go) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         port_active_ff <= '0;
         active_cnt_ff  <= '0;
         free_ports_ff  <= CNT_W'(FREE_RESET);
      end else begin
         stg_valid_ff   <= stg_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         port_active_ff <= port_active_in;
         active_cnt_ff  <= active_cnt_in;
         free_ports_ff  <= free_ports_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stg_type_ff <= req_type;
         stg_port_ff <= req_port_sel;
         stg_src_ff  <= ID_BITS'(req_src_id);
         stg_dst_ff  <= ID_BITS'(req_dst_id);
      end
      if (stage_go) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_port_ff <= rsp_port_in;
         rsp_mask_ff <= rsp_mask_in;
         rsp_hit_ff  <= rsp_hit_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_assigned_port = rsp_port_ff;
   assign rsp_forward_mask  = rsp_mask_ff;
   assign rsp_dest_hit      = rsp_hit_ff;

   // active count tracks the active bits
   a_active_cnt: assert property (@(posedge clock) disable iff (reset)
      active_cnt_ff == CNT_W'($countones(port_active_ff)))
      else $error("active port count out of step with active bits");

   // a granted port is active afterwards
   a_connect_sets: assert property (@(posedge clock) disable iff (reset)
      (stage_go && !csr_wr_en && (stg_type_ff == lsf_pkg::REQ_CONNECT) && connect_ok)
      |=> port_active_ff[$past(free_idx)])
      else $error("connected port not marked active");

   // a destination hit forwards to exactly one port
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> $onehot(rsp_mask_ff))
      else $error("destination hit without one-port mask");

   // a stage advance always loads the result register
   a_stage_flow: assert property (@(posedge clock) disable iff (reset)
      stage_go |=> rsp_valid_ff)
      else $error("stage advanced without loading a result");

endmodule
